// ===== hw/rtl/dlc_pkg.sv =====
// ----------------------------------------------------------------------------
// dlc_pkg
// Shared constants, codes and types of the decimal line calculator.
// ----------------------------------------------------------------------------
package dlc_pkg;

	localparam int unsigned LINE_LIMIT  = 63;
	localparam int unsigned DATA_W      = 64;
	localparam int unsigned CHAR_W      = 8;
	localparam int unsigned DIGIT_W     = 4;
	localparam int unsigned DIGIT_STEPS = DATA_W / DIGIT_W;
	localparam int unsigned DSTEP_W     = $clog2(DIGIT_STEPS);
	localparam int unsigned KEEP_W      = $clog2(LINE_LIMIT + 1);
	localparam int unsigned BIT_W       = $clog2(DATA_W);

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2a;
	localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2f;

	typedef enum logic [2:0] {
		PH_LEAD_A,
		PH_DIGITS_A,
		PH_GAP_OP,
		PH_LEAD_B,
		PH_DIGITS_B,
		PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	typedef enum logic [2:0] {
		ALU_IDLE,
		ALU_MUL,
		ALU_DIV,
		ALU_SIGN,
		ALU_DONE
	} alu_state_t;

	typedef struct packed {
		logic              start;
		op_t               op;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
	} alu_req_t;

	function automatic op_t decode_op(logic [CHAR_W-1:0] c);
		op_t o;
		case (c)
			CH_PLUS:  o = OP_ADD;
			CH_MINUS: o = OP_SUB;
			CH_STAR:  o = OP_MUL;
			CH_SLASH: o = OP_DIV;
			default:  o = OP_NONE;
		endcase
		return o;
	endfunction

endpackage

// ===== hw/rtl/dlc_char_if.sv =====
// ----------------------------------------------------------------------------
// dlc_char_if
// Character channel: one received byte per transfer.
// ----------------------------------------------------------------------------
interface dlc_char_if;
	import dlc_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_in;

	modport source(output valid, output char_in, input ready);
	modport sink(input valid, input char_in, output ready);
endinterface

// ===== hw/rtl/dlc_result_if.sv =====
// ----------------------------------------------------------------------------
// dlc_result_if
// Result channel: one evaluated line per transfer.
// ----------------------------------------------------------------------------
interface dlc_result_if;
	import dlc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] result_value;
	logic                     divide_by_zero;

	modport source(output valid, output result_value, output divide_by_zero, input ready);
	modport sink(input valid, input result_value, input divide_by_zero, output ready);
endinterface

// ===== hw/rtl/dlc_parse.sv =====
// ----------------------------------------------------------------------------
// dlc_parse
// Line parser with a nibble-serial multiply-by-ten accumulator.
// ----------------------------------------------------------------------------
module dlc_parse (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [dlc_pkg::CHAR_W-1:0] char_in,
	input  logic                      alu_idle,
	output dlc_pkg::alu_req_t         req
);
	import dlc_pkg::*;

	phase_t              phase_q, phase_d;
	op_t                 op_q, op_d;
	logic [DATA_W-1:0]   a_q, a_d, b_q, b_d;
	logic [KEEP_W-1:0]   kept_q, kept_d;
	logic                busy_q, busy_d;
	logic                sel_b_q, sel_b_d;
	logic [DIGIT_W-1:0]  carry_q, carry_d;
	logic [DSTEP_W-1:0]  step_q, step_d;

	logic                accept;
	logic                is_end, is_digit, is_space;
	logic [DIGIT_W-1:0]  dval;
	logic [DIGIT_W-1:0]  nib;
	logic [7:0]          prod;
	logic [DATA_W-1:0]   shifted;

	assign in_ready = !busy_q && alu_idle;
	assign accept   = in_valid && in_ready;
	assign is_end   = (char_in == CH_LF) || (char_in == CH_CR);
	assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
	assign is_space = (char_in == CH_SPACE);
	assign dval     = char_in[DIGIT_W-1:0];

	assign nib     = sel_b_q ? b_q[DIGIT_W-1:0] : a_q[DIGIT_W-1:0];
	assign prod    = {4'b0, nib} * 8'd10 + {4'b0, carry_q};
	assign shifted = {prod[DIGIT_W-1:0],
		(sel_b_q ? b_q[DATA_W-1:DIGIT_W] : a_q[DATA_W-1:DIGIT_W])};

	assign req.start = accept && is_end;
	assign req.op    = op_q;
	assign req.a     = a_q;
	assign req.b     = b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD_A;
			op_q    <= OP_NONE;
			a_q     <= '0;
			b_q     <= '0;
			kept_q  <= '0;
			busy_q  <= 1'b0;
			sel_b_q <= 1'b0;
			carry_q <= '0;
			step_q  <= '0;
		end else begin
			phase_q <= phase_d;
			op_q    <= op_d;
			a_q     <= a_d;
			b_q     <= b_d;
			kept_q  <= kept_d;
			busy_q  <= busy_d;
			sel_b_q <= sel_b_d;
			carry_q <= carry_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		op_d    = op_q;
		a_d     = a_q;
		b_d     = b_q;
		kept_d  = kept_q;
		busy_d  = busy_q;
		sel_b_d = sel_b_q;
		carry_d = carry_q;
		step_d  = step_q;

		if (busy_q) begin
			// advance one nibble of x*10 + d
			if (sel_b_q) begin
				b_d = shifted;
			end else begin
				a_d = shifted;
			end
			carry_d = prod[7:DIGIT_W];
			step_d  = step_q + 1'b1;
			if (step_q == DSTEP_W'(DIGIT_STEPS - 1)) begin
				busy_d = 1'b0;
			end
		end else if (accept) begin
			if (is_end) begin
				phase_d = PH_LEAD_A;
				op_d    = OP_NONE;
				a_d     = '0;
				b_d     = '0;
				kept_d  = '0;
			end else if (kept_q < KEEP_W'(LINE_LIMIT)) begin
				kept_d = kept_q + 1'b1;
				case (phase_q)
					PH_LEAD_A: begin
						if (is_space) begin
						end else if (is_digit) begin
							a_d     = DATA_W'(dval);
							phase_d = PH_DIGITS_A;
						end else if (char_in == CH_NUL) begin
							op_d    = OP_NONE;
							phase_d = PH_DONE;
						end else begin
							op_d    = decode_op(char_in);
							phase_d = PH_LEAD_B;
						end
					end
					PH_DIGITS_A: begin
						if (is_digit) begin
							busy_d  = 1'b1;
							sel_b_d = 1'b0;
							carry_d = dval;
							step_d  = '0;
						end else if (is_space) begin
							phase_d = PH_GAP_OP;
						end else if (char_in == CH_NUL) begin
							op_d    = OP_NONE;
							phase_d = PH_DONE;
						end else begin
							op_d    = decode_op(char_in);
							phase_d = PH_LEAD_B;
						end
					end
					PH_GAP_OP: begin
						if (is_space) begin
						end else if (char_in == CH_NUL) begin
							op_d    = OP_NONE;
							phase_d = PH_DONE;
						end else begin
							op_d    = decode_op(char_in);
							phase_d = PH_LEAD_B;
						end
					end
					PH_LEAD_B: begin
						if (is_space) begin
						end else if (is_digit) begin
							b_d     = DATA_W'(dval);
							phase_d = PH_DIGITS_B;
						end else begin
							phase_d = PH_DONE;
						end
					end
					PH_DIGITS_B: begin
						if (is_digit) begin
							busy_d  = 1'b1;
							sel_b_d = 1'b1;
							carry_d = dval;
							step_d  = '0;
						end else begin
							phase_d = PH_DONE;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// ===== hw/rtl/dlc_alu.sv =====
// ----------------------------------------------------------------------------
// dlc_alu
// Line evaluator: shift-add multiply, restoring divide, output register.
// ----------------------------------------------------------------------------
module dlc_alu (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dlc_pkg::alu_req_t         req,
	output logic                      idle,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [dlc_pkg::DATA_W-1:0] out_value,
	output logic                      out_dz
);
	import dlc_pkg::*;

	alu_state_t          state_q, state_d;
	logic [DATA_W-1:0]   x_q, x_d, y_q, y_d, acc_q, acc_d, res_q, res_d;
	logic                dz_q, dz_d, neg_q, neg_d;
	logic [BIT_W-1:0]    cnt_q, cnt_d;
	logic                ov_q, ov_d;
	logic [DATA_W-1:0]   ovalue_q, ovalue_d;
	logic                odz_q, odz_d;

	logic [DATA_W:0]     rem_sh, diff;
	logic                last;

	assign idle      = (state_q == ALU_IDLE);
	assign out_valid = ov_q;
	assign out_value = ovalue_q;
	assign out_dz    = odz_q;

	assign rem_sh = {x_q, y_q[DATA_W-1]};
	assign diff   = rem_sh - {1'b0, acc_q};
	assign last   = (cnt_q == BIT_W'(DATA_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ALU_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			ov_q    <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		x_q      <= x_d;
		y_q      <= y_d;
		acc_q    <= acc_d;
		res_q    <= res_d;
		dz_q     <= dz_d;
		neg_q    <= neg_d;
		cnt_q    <= cnt_d;
		ovalue_q <= ovalue_d;
		odz_q    <= odz_d;
	end

	always_comb begin
		state_d  = state_q;
		x_d      = x_q;
		y_d      = y_q;
		acc_d    = acc_q;
		res_d    = res_q;
		dz_d     = dz_q;
		neg_d    = neg_q;
		cnt_d    = cnt_q;
		ov_d     = ov_q && !out_ready;
		ovalue_d = ovalue_q;
		odz_d    = odz_q;

		case (state_q)
			ALU_IDLE: begin
				if (req.start) begin
					dz_d    = 1'b0;
					cnt_d   = '0;
					state_d = ALU_DONE;
					case (req.op)
						OP_ADD: res_d = req.a + req.b;
						OP_SUB: res_d = req.a - req.b;
						OP_MUL: begin
							x_d     = req.a;
							y_d     = req.b;
							acc_d   = '0;
							state_d = ALU_MUL;
						end
						OP_DIV: begin
							if (req.b == '0) begin
								res_d = '0;
								dz_d  = 1'b1;
							end else begin
								neg_d   = req.a[DATA_W-1] ^ req.b[DATA_W-1];
								x_d     = '0;
								y_d     = req.a[DATA_W-1] ? (~req.a + 1'b1) : req.a;
								acc_d   = req.b[DATA_W-1] ? (~req.b + 1'b1) : req.b;
								state_d = ALU_DIV;
							end
						end
						default: res_d = req.a;
					endcase
				end
			end
			ALU_MUL: begin
				if (y_q[0]) begin
					acc_d = acc_q + x_q;
				end
				x_d   = {x_q[DATA_W-2:0], 1'b0};
				y_d   = {1'b0, y_q[DATA_W-1:1]};
				cnt_d = cnt_q + 1'b1;
				if (last) begin
					res_d   = acc_d;
					state_d = ALU_DONE;
				end
			end
			ALU_DIV: begin
				if (!diff[DATA_W]) begin
					x_d = diff[DATA_W-1:0];
				end else begin
					x_d = rem_sh[DATA_W-1:0];
				end
				y_d   = {y_q[DATA_W-2:0], !diff[DATA_W]};
				cnt_d = cnt_q + 1'b1;
				if (last) begin
					state_d = ALU_SIGN;
				end
			end
			ALU_SIGN: begin
				res_d   = neg_q ? (~y_q + 1'b1) : y_q;
				state_d = ALU_DONE;
			end
			ALU_DONE: begin
				if (!ov_q || out_ready) begin
					ov_d     = 1'b1;
					ovalue_d = res_q;
					odz_d    = dz_q;
					state_d  = ALU_IDLE;
				end
			end
			default: state_d = ALU_IDLE;
		endcase
	end

endmodule

// ===== hw/rtl/decimal_line_calculator_unit.sv =====
// ----------------------------------------------------------------------------
// decimal_line_calculator_unit
// Parses "a op b" lines one character at a time and returns a op b.
// ----------------------------------------------------------------------------
//  channel      dir  payload                          transfer
//  char_chan    in   char_in[7:0]                     valid && ready
//  result_chan  out  result_value[63:0], divide_by_zero  valid && ready
//
//  Digits after the first of a number take the transfer plus a 16-step
//  nibble-serial x10 pass over the operand. A line end yields its result
//  through the done state and the output register for + - and no operator;
//  * takes one bit per cycle and / one quotient bit per cycle plus a sign step.
//  Characters are taken while a result waits in the output register, and none
//  while the evaluator works on a line or holds a result behind a stalled one.
//  arst_n clears the parser and the evaluator; no clearing pass.
// ----------------------------------------------------------------------------
module decimal_line_calculator_unit (
	input  logic          clk,
	input  logic          arst_n,
	dlc_char_if.sink      char_chan,
	dlc_result_if.source  result_chan
);
	import dlc_pkg::*;

	alu_req_t          req;
	logic              alu_idle;
	logic [DATA_W-1:0] value;

	dlc_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (char_chan.valid),
		.in_ready (char_chan.ready),
		.char_in  (char_chan.char_in),
		.alu_idle (alu_idle),
		.req      (req)
	);

	dlc_alu u_alu (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.idle      (alu_idle),
		.out_valid (result_chan.valid),
		.out_ready (result_chan.ready),
		.out_value (value),
		.out_dz    (result_chan.divide_by_zero)
	);

	assign result_chan.result_value = $signed(value);

endmodule

// ===== hw/rtl/dlc_checker.sv =====
// ----------------------------------------------------------------------------
// dlc_checker
// Port-level checks of the decimal line calculator, bound to the top level.
// ----------------------------------------------------------------------------
module dlc_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic [dlc_pkg::CHAR_W-1:0] char_in,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [dlc_pkg::DATA_W-1:0] result_value,
	input logic                      divide_by_zero
);
	import dlc_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(result_value) && $stable(divide_by_zero))
		else $error("result changed while stalled");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> result_value == '0)
		else $error("divide by zero with nonzero result");

	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (char_in == CH_LF || char_in == CH_CR) |=> !in_ready)
		else $error("input ready right after a line end transfer");

endmodule

bind decimal_line_calculator_unit dlc_checker u_dlc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (char_chan.valid),
	.in_ready       (char_chan.ready),
	.char_in        (char_chan.char_in),
	.out_valid      (result_chan.valid),
	.out_ready      (result_chan.ready),
	.result_value   (result_chan.result_value),
	.divide_by_zero (result_chan.divide_by_zero)
);

// ===== verif/dlc_line_checker.sv =====
// ----------------------------------------------------------------------------
// dlc_line_checker
// Watches both channels of the decimal line calculator, evaluates each line
// from its received characters and compares every returned result with the
// oldest evaluated line still waiting.
// ----------------------------------------------------------------------------
module dlc_line_checker (
	input  logic   clk,
	input  logic   arst_n,
	dlc_char_if    char_chan,
	dlc_result_if  result_chan,
	output int     fail_count,
	output int     pending,
	output int     results_checked,
	output int     div_zero_seen
);
	import dlc_pkg::*;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              dz;
	} line_answer_t;

	line_answer_t      answers[$];
	phase_t            ph       = PH_LEAD_A;
	logic [DATA_W-1:0] opa      = '0;
	logic [DATA_W-1:0] opb      = '0;
	logic [CHAR_W-1:0] opch     = CH_NUL;
	logic [KEEP_W-1:0] kept     = '0;

	initial begin
		fail_count      = 0;
		pending         = 0;
		results_checked = 0;
		div_zero_seen   = 0;
	end

	function automatic bit is_digit(logic [CHAR_W-1:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic [DATA_W-1:0] truncated_quotient(logic [DATA_W-1:0] num,
			logic [DATA_W-1:0] den);
		logic [DATA_W-1:0] mn;
		logic [DATA_W-1:0] md;
		logic [DATA_W-1:0] q;
		mn = num[DATA_W-1] ? -num : num;
		md = den[DATA_W-1] ? -den : den;
		q  = mn / md;
		return (num[DATA_W-1] ^ den[DATA_W-1]) ? -q : q;
	endfunction

	task automatic clear_line();
		ph   = PH_LEAD_A;
		opa  = '0;
		opb  = '0;
		opch = CH_NUL;
		kept = '0;
	endtask

	task automatic take_operator(logic [CHAR_W-1:0] c);
		opch = c;
		ph   = (c == CH_NUL) ? PH_DONE : PH_LEAD_B;
	endtask

	task automatic evaluate_line();
		line_answer_t ans;
		ans.value = opa;
		ans.dz    = 1'b0;
		case (opch)
			CH_PLUS:  ans.value = opa + opb;
			CH_MINUS: ans.value = opa - opb;
			CH_STAR:  ans.value = opa * opb;
			CH_SLASH: begin
				if (opb == '0) begin
					ans.value = '0;
					ans.dz    = 1'b1;
				end else begin
					ans.value = truncated_quotient(opa, opb);
				end
			end
			default: ;
		endcase
		answers.push_back(ans);
		clear_line();
	endtask

	task automatic parse_char(logic [CHAR_W-1:0] c);
		if (c == CH_LF || c == CH_CR) begin
			evaluate_line();
		end else if (kept < LINE_LIMIT) begin
			kept++;
			case (ph)
				PH_LEAD_A: begin
					if (is_digit(c)) begin
						opa = 64'(c - CH_ZERO);
						ph  = PH_DIGITS_A;
					end else if (c != CH_SPACE) begin
						take_operator(c);
					end
				end
				PH_DIGITS_A: begin
					if (is_digit(c)) begin
						opa = opa * 64'd10 + 64'(c - CH_ZERO);
					end else if (c == CH_SPACE) begin
						ph = PH_GAP_OP;
					end else begin
						take_operator(c);
					end
				end
				PH_GAP_OP: begin
					if (c != CH_SPACE)
						take_operator(c);
				end
				PH_LEAD_B: begin
					if (is_digit(c)) begin
						opb = 64'(c - CH_ZERO);
						ph  = PH_DIGITS_B;
					end else if (c != CH_SPACE) begin
						ph = PH_DONE;
					end
				end
				PH_DIGITS_B: begin
					if (is_digit(c))
						opb = opb * 64'd10 + 64'(c - CH_ZERO);
					else
						ph = PH_DONE;
				end
				default: ;
			endcase
		end
	endtask

	task automatic check_result();
		line_answer_t want;
		if (answers.size() == 0) begin
			$error("unexpected result: result_value %0d divide_by_zero %0b",
				result_chan.result_value, result_chan.divide_by_zero);
			fail_count++;
		end else begin
			want = answers.pop_front();
			results_checked++;
			if (result_chan.divide_by_zero)
				div_zero_seen++;
			if (result_chan.result_value !== want.value) begin
				$error("result_value expected %0d actual %0d",
					$signed(want.value), result_chan.result_value);
				fail_count++;
			end
			if (result_chan.divide_by_zero !== want.dz) begin
				$error("divide_by_zero expected %0b actual %0b",
					want.dz, result_chan.divide_by_zero);
				fail_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_line();
			answers.delete();
		end else begin
			if (result_chan.valid && result_chan.ready)
				check_result();
			if (char_chan.valid && char_chan.ready)
				parse_char(char_chan.char_in);
		end
		pending = answers.size();
	end

endmodule

// ===== verif/decimal_line_calculator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// decimal_line_calculator_unit_tb
// Feeds directed and random text lines, one character per transfer, with
// random source gaps and sink stalls; a side checker evaluates every line and
// compares each returned result.
// ----------------------------------------------------------------------------
module decimal_line_calculator_unit_tb;
	import dlc_pkg::*;

	localparam int CHAR_TARGET = 1550;

	logic clk;
	logic arst_n;

	dlc_char_if   char_chan();
	dlc_result_if result_chan();

	int fail_count;
	int pending;
	int results_checked;
	int div_zero_seen;

	logic [CHAR_W-1:0] line_buf[$];
	logic [CHAR_W-1:0] op_chars[4] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
	int                chars_sent;
	int                lines_sent;
	bit                tx_calm;
	bit                rx_calm;

	decimal_line_calculator_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_chan   (char_chan),
		.result_chan (result_chan)
	);

	dlc_line_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.char_chan       (char_chan),
		.result_chan     (result_chan),
		.fail_count      (fail_count),
		.pending         (pending),
		.results_checked (results_checked),
		.div_zero_seen   (div_zero_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("decimal_line_calculator_unit verification failed");
		$finish;
	end

	function automatic int idle_len();
		return ($urandom_range(0, 99) < 88) ? $urandom_range(1, 3) : $urandom_range(4, 40);
	endfunction

	function automatic logic [CHAR_W-1:0] noise_byte();
		logic [CHAR_W-1:0] c;
		do
			c = CHAR_W'($urandom_range(0, 255));
		while (c == CH_LF || c == CH_CR);
		return c;
	endfunction

	function automatic int digit_span();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return $urandom_range(1, 3);
		if (r < 85)
			return $urandom_range(4, 9);
		if (r < 97)
			return $urandom_range(10, 20);
		return $urandom_range(21, 25);
	endfunction

	task automatic put_str(string s);
		for (int i = 0; i < s.len(); i++)
			line_buf.push_back(s[i]);
	endtask

	task automatic put_spaces(int n);
		repeat (n) line_buf.push_back(CH_SPACE);
	endtask

	task automatic put_digits(int n);
		repeat (n) line_buf.push_back(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
	endtask

	task automatic send_char(logic [CHAR_W-1:0] c);
		int gap;
		gap = 0;
		if (!tx_calm && $urandom_range(0, 99) < 35)
			gap = idle_len();
		if (gap > 0) begin
			char_chan.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_chan.valid   <= 1'b1;
		char_chan.char_in <= c;
		do
			@(posedge clk);
		while (!char_chan.ready);
	endtask

	task automatic send_line(logic [CHAR_W-1:0] eol);
		if ($urandom_range(0, 99) < 5)
			tx_calm = !tx_calm;
		foreach (line_buf[i]) begin
			send_char(line_buf[i]);
			if (i < LINE_LIMIT)
				chars_sent++;
		end
		send_char(eol);
		chars_sent++;
		lines_sent++;
		line_buf.delete();
	endtask

	task automatic build_random_line();
		int kind;
		int r;
		kind = $urandom_range(0, 99);
		if (kind < 88) begin
			put_spaces(($urandom_range(0, 99) < 4) ? $urandom_range(40, 62) : $urandom_range(0, 2));
			put_digits(digit_span());
			put_spaces($urandom_range(0, 2));
			if ($urandom_range(0, 99) < 85)
				line_buf.push_back(op_chars[$urandom_range(0, 3)]);
			else
				line_buf.push_back(noise_byte());
			put_spaces($urandom_range(0, 2));
			r = $urandom_range(0, 99);
			if (r < 8)
				;
			else if (r < 16)
				line_buf.push_back(CH_ZERO);
			else
				put_digits(digit_span());
			if ($urandom_range(0, 99) < 10)
				line_buf.push_back(noise_byte());
			if (kind >= 73)
				line_buf[$urandom_range(0, line_buf.size() - 1)] = noise_byte();
		end else begin
			repeat ($urandom_range(0, 12)) line_buf.push_back(noise_byte());
		end
	endtask

	initial begin
		result_chan.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			int stall;
			stall = 0;
			@(posedge clk);
			if ($urandom_range(0, 499) == 0)
				rx_calm = !rx_calm;
			if (!rx_calm && $urandom_range(0, 99) < 25)
				stall = idle_len();
			if (stall > 0) begin
				result_chan.ready <= 1'b0;
				repeat (stall - 1) @(posedge clk);
			end else begin
				result_chan.ready <= 1'b1;
			end
		end
	end

	initial begin
		arst_n            <= 1'b0;
		char_chan.valid   <= 1'b0;
		char_chan.char_in <= '0;
		chars_sent = 0;
		lines_sent = 0;
		tx_calm    = 1'b0;
		rx_calm    = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_line(CH_LF);
		put_str("12+34");                                     send_line(CH_CR);
		put_str("  7 - 9");                                   send_line(CH_LF);
		put_str("6*7");                                       send_line(CH_LF);
		put_str("100/7");                                     send_line(CH_LF);
		put_str("9/0");                                       send_line(CH_LF);
		put_str("8 /");                                       send_line(CH_CR);
		put_str("18446744073709551615+1");                    send_line(CH_LF);
		put_str("9223372036854775808/18446744073709551615");  send_line(CH_LF);
		put_str("5/18446744073709551615");                    send_line(CH_LF);
		put_str("99999999999999999999*99999999999999999999"); send_line(CH_CR);
		put_str("12 3");                                      send_line(CH_LF);
		put_str("4+x7");                                      send_line(CH_LF);
		put_str("42");                                        send_line(CH_LF);
		put_str("3");
		line_buf.push_back(CH_NUL);
		put_str("+4");                                        send_line(CH_LF);
		put_str("3+4");
		line_buf.push_back(CH_NUL);
		put_str("9");                                         send_line(CH_CR);
		line_buf.push_back(CH_NUL);
		put_str("5");                                         send_line(CH_LF);
		put_str("5%3");                                       send_line(CH_LF);
		put_str("1 + 2 3");                                   send_line(CH_LF);
		put_str("- 5");                                       send_line(CH_LF);
		put_spaces(60);
		put_str("1+2");                                       send_line(CH_LF);
		put_spaces(61);
		put_str("1+2");                                       send_line(CH_CR);
		put_str("7+");
		put_spaces(65);
		put_str("5");                                         send_line(CH_LF);
		put_str("5*5");                                       send_line(CH_CR);
		send_line(CH_LF);

		while (chars_sent < CHAR_TARGET) begin
			build_random_line();
			send_line(($urandom_range(0, 1) != 0) ? CH_LF : CH_CR);
		end
		char_chan.valid <= 1'b0;

		@(posedge clk);
		wait (pending == 0);
		repeat (100) @(posedge clk);
		$display("Drove %0d characters over %0d lines; %0d results compared, %0d divide by zero.",
			chars_sent, lines_sent, results_checked, div_zero_seen);
		if (fail_count == 0)
			$display("decimal_line_calculator_unit verification clean");
		else
			$display("decimal_line_calculator_unit verification failed");
		$finish;
	end

endmodule

// ===== decimal_line_calculator_unit.f =====
hw/rtl/dlc_pkg.sv
hw/rtl/dlc_char_if.sv
hw/rtl/dlc_result_if.sv
hw/rtl/dlc_parse.sv
hw/rtl/dlc_alu.sv
hw/rtl/decimal_line_calculator_unit.sv
hw/rtl/dlc_checker.sv
verif/dlc_line_checker.sv
verif/decimal_line_calculator_unit_tb.sv
